### src/monte_carlo_call_path_accumulator_defines.svh
// ---------------------------------------------------------------------------
// monte carlo call path accumulator assertion macros
// shared property forms for the accumulator rtl, clocked on clk, reset arst_n
// ---------------------------------------------------------------------------
`ifndef MONTE_CARLO_CALL_PATH_ACCUMULATOR_DEFINES_SVH
`define MONTE_CARLO_CALL_PATH_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define MCPA_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCPA_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/mcpa_pkg.sv
// ---------------------------------------------------------------------------
// mcpa package
// constants, types and tables shared by the call path accumulator
// ---------------------------------------------------------------------------
package mcpa_pkg;

	localparam int PATH_COUNT_BITS_DEF = 24;
	localparam int EXP_POLY_DEGREE_DEF = 7;

	localparam int MUL_W     = 33;
	localparam int OUT_W     = 352;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SPOT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIKE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DISC   = 3'd4;

	localparam logic [31:0] SPOT_RST   = 32'd6553600;
	localparam logic [31:0] STRIKE_RST = 32'd6553600;
	localparam logic [31:0] DRIFT_RST  = 32'd8053064;
	localparam logic [30:0] VOL_RST    = 31'd53687091;
	localparam logic [31:0] DISC_RST   = 32'd2042749629;

	localparam logic [27:0] LN2_Q28 = 28'd186065280;
	localparam logic [37:0] DIV_D   = 38'd372130560;
	// floor(2^60 / DIV_D)
	localparam logic [31:0] DIV_RECIP = 32'd3098164000;

	typedef struct packed {
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mul_op_t;

	typedef struct packed {
		logic        ovf;
		logic [63:0] val;
	} scale_t;

	typedef enum logic [1:0] {
		DS_PLAIN,
		DS_ANTI,
		DS_DELTA
	} disc_sel_t;

	typedef enum logic [19:0] {
		S_IDLE    = 20'h00001,
		S_SHOCK   = 20'h00002,
		S_LOGX    = 20'h00004,
		S_DIV     = 20'h00008,
		S_QMUL    = 20'h00010,
		S_FIX     = 20'h00020,
		S_REDUCE  = 20'h00040,
		S_H_ISSUE = 20'h00080,
		S_H_TAKE  = 20'h00100,
		S_RATIO   = 20'h00200,
		S_PRICE   = 20'h00400,
		S_AVG     = 20'h00800,
		S_D_LO    = 20'h01000,
		S_D_HI    = 20'h02000,
		S_D_SUM   = 20'h04000,
		S_SQ_LL   = 20'h08000,
		S_SQ_LH   = 20'h10000,
		S_SQ_HH   = 20'h20000,
		S_SQ_END  = 20'h40000,
		S_ACC     = 20'h80000
	} state_t;

	// 1/n! in q4.28
	function automatic logic signed [31:0] exp_coef(input int unsigned n);
		logic signed [31:0] c;
		case (n)
			0: c = 32'sd268435456;
			1: c = 32'sd268435456;
			2: c = 32'sd134217728;
			3: c = 32'sd44739243;
			4: c = 32'sd11184811;
			5: c = 32'sd2236962;
			6: c = 32'sd372827;
			7: c = 32'sd53261;
			8: c = 32'sd6658;
			9: c = 32'sd740;
			10: c = 32'sd74;
			default: c = 32'sd0;
		endcase
		return c;
	endfunction

endpackage

### src/mcpa_mul.sv
// ---------------------------------------------------------------------------
// mcpa shared multiplier
// signed 33 by 33 multiplier with a registered product
// ---------------------------------------------------------------------------
module mcpa_mul import mcpa_pkg::*; (
	input  logic                      clk,
	input  mul_op_t                   op,
	output logic signed [2*MUL_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op.a * op.b;
	end

endmodule

### src/monte_carlo_call_path_accumulator.sv
// ---------------------------------------------------------------------------
// monte carlo call path accumulator
// antithetic european call payoff, square and delta sums per batch
// ---------------------------------------------------------------------------
// Each request carries one q4.12 normal shock; the block is ready for another
// only after it has finished this one: every product goes through one registered
// 33x33 multiplier, the range reduction per leg is a reciprocal multiply, a
// quotient times divisor product and one correction step, and each Horner step
// is an issue state and a take state. A request with tlast high emits the five
// sums, path count and overflow flag into an output register and clears the
// sums; the next request is taken while that result waits.
// ---------------------------------------------------------------------------
`include "monte_carlo_call_path_accumulator_defines.svh"

module monte_carlo_call_path_accumulator import mcpa_pkg::*; #(
	parameter int PATH_COUNT_BITS = PATH_COUNT_BITS_DEF,
	parameter int EXP_POLY_DEGREE = EXP_POLY_DEGREE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // normal_sample
	input  logic                 s_tlast,   // last_path
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// plain_payoff_sum, plain_square_sum, antithetic_sum, antithetic_square_sum,
	// delta_sum, paths_done, sum_overflow, zero fill
	output logic [OUT_W-1:0]     m_tdata
);

	localparam int CW = PATH_COUNT_BITS + 1;
	localparam int HW = $clog2(EXP_POLY_DEGREE);

	state_t state_q;

	logic [31:0]        spot_q, strike_q, disc_q;
	logic signed [31:0] drift_q;
	logic [30:0]        vol_q;

	logic signed [15:0] z_q;
	logic               last_q, ovf_q, leg_q, neg_q, sqsel_q;
	logic signed [34:0] t_q;
	logic [37:0]        rem_q;
	logic [7:0]         quo_q;
	logic signed [8:0]  k_q;
	logic signed [31:0] r_q, acc_q;
	logic [HW-1:0]      horn_i_q;
	logic [63:0]        ratio_q, pay_p_q, pay_m_q, dfac_p_q, dfac_m_q;
	logic [63:0]        hs_pay_q, hs_d_q, plain_q, anti_q, dlt_q, psq_q, asq_q;
	disc_sel_t          dsel_q;
	logic [32:0]        dlo_q;
	logic [127:0]       sq_q;

	logic [63:0]   plain_acc_q, plain_sq_acc_q, anti_acc_q, anti_sq_acc_q, delta_acc_q;
	logic [CW-1:0] cnt_q;
	logic          seen_q, out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	mul_op_t                   mop;
	logic signed [2*MUL_W-1:0] prod;

	mcpa_mul u_mul (
		.clk    (clk),
		.op     (mop),
		.prod_q (prod)
	);

	function automatic scale_t scale_pow2(input logic [63:0] m, input logic signed [10:0] sh);
		logic [127:0] wide;
		logic [10:0]  n;
		scale_t       res;
		res  = '0;
		wide = '0;
		n    = '0;
		if (!sh[10]) begin
			if (m != '0) begin
				if (sh > 11'sd63) begin
					res.ovf = 1'b1;
					res.val = '1;
				end else begin
					wide = {64'd0, m} << sh[5:0];
					if (wide[127:64] != '0) begin
						res.ovf = 1'b1;
						res.val = '1;
					end else begin
						res.val = wide[63:0];
					end
				end
			end
		end else begin
			n = 11'(-sh);
			if (n <= 11'd63)
				res.val = m >> n[5:0];
		end
		return res;
	endfunction

	function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[64])
			s = {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
		return s;
	endfunction

	function automatic logic [63:0] half_sum(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64:1];
	endfunction

	// datapath helpers
	logic               in_go, acc_go;
	logic signed [34:0] t_now;
	logic signed [36:0] x_cur;
	logic [36:0]        ax;
	logic [37:0]        rem_init;
	logic [37:0]        rfix;
	logic signed [29:0] rdiff, rmag;
	logic signed [8:0]  kq;
	logic [31:0]        e_val;
	logic [63:0]        sc_m, dval, sv, price;
	logic signed [10:0] sc_sh;
	scale_t             sc;
	logic [65:0]        dsum;
	logic [63:0]        dres;
	logic               dovf;
	logic [127:0]       sq_full;
	logic [63:0]        sq_res;
	logic               sq_ovf;
	logic [64:0]        n_plain, n_psq, n_anti, n_asq, n_dlt;
	logic [CW-1:0]      cnt_next;
	logic               ovf_all;

	assign s_tready = (state_q == S_IDLE);
	assign in_go    = s_tvalid && s_tready;
	assign acc_go   = (state_q == S_ACC) && !(last_q && out_valid_q && !m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign t_now    = prod[46:12];
	assign x_cur    = leg_q ? (37'(drift_q) - 37'(t_q)) : (37'(drift_q) + 37'(t_now));
	assign ax       = x_cur[36] ? 37'(-x_cur) : 37'(x_cur);
	assign rem_init = {ax, 1'b0} + 38'(LN2_Q28);
	assign rfix     = rem_q - prod[37:0];
	assign rdiff    = $signed({1'b0, rem_q[28:0]}) - $signed({2'b00, LN2_Q28});
	assign rmag     = rdiff >>> 1;
	assign kq       = $signed({1'b0, quo_q});
	assign e_val    = acc_q[31] ? 32'd0 : acc_q;

	assign sc_m  = (state_q == S_RATIO) ? 64'(e_val) : prod[63:0];
	assign sc_sh = 11'(k_q) - ((state_q == S_RATIO) ? 11'sd12 : 11'sd28);
	assign sc    = scale_pow2(sc_m, sc_sh);
	assign price = sc.val;

	always_comb begin
		case (dsel_q)
			DS_PLAIN: dval = pay_p_q;
			DS_ANTI:  dval = hs_pay_q;
			DS_DELTA: dval = hs_d_q;
			default:  dval = '0;
		endcase
	end

	assign sv = sqsel_q ? anti_q : plain_q;

	assign dsum = {1'b0, prod[63:0], 1'b0} + 66'(dlo_q);
	assign dovf = (dsum[65:64] != 2'b00);
	assign dres = dovf ? '1 : dsum[63:0];

	assign sq_full = sq_q + (128'(prod[63:0]) << 64);
	assign sq_ovf  = (sq_full[127:80] != '0);
	assign sq_res  = sq_ovf ? '1 : sq_full[79:16];

	assign n_plain  = sat_add(plain_acc_q, plain_q);
	assign n_psq    = sat_add(plain_sq_acc_q, psq_q);
	assign n_anti   = sat_add(anti_acc_q, anti_q);
	assign n_asq    = sat_add(anti_sq_acc_q, asq_q);
	assign n_dlt    = sat_add(delta_acc_q, dlt_q);
	assign ovf_all  = ovf_q | n_plain[64] | n_psq[64] | n_anti[64] | n_asq[64] | n_dlt[64];
	assign cnt_next = cnt_q[CW-1] ? cnt_q : cnt_q + 1'b1;

	// multiplier operand select
	always_comb begin
		mop = '0;
		case (state_q)
			S_SHOCK: begin
				mop.a = MUL_W'(vol_q);
				mop.b = MUL_W'(z_q);
			end
			S_DIV: begin
				mop.a = MUL_W'(rem_q[35:4]);
				mop.b = MUL_W'(DIV_RECIP);
			end
			S_QMUL: begin
				mop.a = MUL_W'(prod[63:56]);
				mop.b = MUL_W'(DIV_D);
			end
			S_H_ISSUE: begin
				mop.a = MUL_W'(acc_q);
				mop.b = MUL_W'(r_q);
			end
			S_RATIO: begin
				mop.a = MUL_W'(spot_q);
				mop.b = MUL_W'(e_val);
			end
			S_D_LO: begin
				mop.a = MUL_W'(disc_q);
				mop.b = MUL_W'(dval[31:0]);
			end
			S_D_HI: begin
				mop.a = MUL_W'(disc_q);
				mop.b = MUL_W'(dval[63:32]);
			end
			S_SQ_LL: begin
				mop.a = MUL_W'(sv[31:0]);
				mop.b = MUL_W'(sv[31:0]);
			end
			S_SQ_LH: begin
				mop.a = MUL_W'(sv[31:0]);
				mop.b = MUL_W'(sv[63:32]);
			end
			S_SQ_HH: begin
				mop.a = MUL_W'(sv[63:32]);
				mop.b = MUL_W'(sv[63:32]);
			end
			default: mop = '0;
		endcase
	end

	// sequencer, registers and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			spot_q         <= SPOT_RST;
			strike_q       <= STRIKE_RST;
			drift_q        <= DRIFT_RST;
			vol_q          <= VOL_RST;
			disc_q         <= DISC_RST;
			plain_acc_q    <= '0;
			plain_sq_acc_q <= '0;
			anti_acc_q     <= '0;
			anti_sq_acc_q  <= '0;
			delta_acc_q    <= '0;
			cnt_q          <= '0;
			seen_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SPOT:   spot_q   <= cfg_data;
					REG_STRIKE: strike_q <= cfg_data;
					REG_DRIFT:  drift_q  <= cfg_data;
					REG_VOL:    vol_q    <= cfg_data[30:0];
					REG_DISC:   disc_q   <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && m_tready && !(acc_go && last_q))
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE:    if (in_go) state_q <= S_SHOCK;
				S_SHOCK:   state_q <= S_LOGX;
				S_LOGX:    state_q <= S_DIV;
				S_DIV:     state_q <= S_QMUL;
				S_QMUL:    state_q <= S_FIX;
				S_FIX:     state_q <= S_REDUCE;
				S_REDUCE:  state_q <= S_H_ISSUE;
				S_H_ISSUE: state_q <= S_H_TAKE;
				S_H_TAKE:  state_q <= (horn_i_q == '0) ? S_RATIO : S_H_ISSUE;
				S_RATIO:   state_q <= S_PRICE;
				S_PRICE:   state_q <= leg_q ? S_AVG : S_LOGX;
				S_AVG:     state_q <= S_D_LO;
				S_D_LO:    state_q <= S_D_HI;
				S_D_HI:    state_q <= S_D_SUM;
				S_D_SUM:   state_q <= (dsel_q == DS_DELTA) ? S_SQ_LL : S_D_LO;
				S_SQ_LL:   state_q <= S_SQ_LH;
				S_SQ_LH:   state_q <= S_SQ_HH;
				S_SQ_HH:   state_q <= S_SQ_END;
				S_SQ_END:  state_q <= sqsel_q ? S_ACC : S_SQ_LL;
				S_ACC: begin
					if (acc_go) begin
						state_q <= S_IDLE;
						if (last_q) begin
							out_valid_q    <= 1'b1;
							out_data_q     <= {6'd0, seen_q | ovf_all, 25'(cnt_next),
								n_dlt[63:0], n_asq[63:0], n_anti[63:0], n_psq[63:0],
								n_plain[63:0]};
							plain_acc_q    <= '0;
							plain_sq_acc_q <= '0;
							anti_acc_q     <= '0;
							anti_sq_acc_q  <= '0;
							delta_acc_q    <= '0;
							cnt_q          <= '0;
							seen_q         <= 1'b0;
						end else begin
							plain_acc_q    <= n_plain[63:0];
							plain_sq_acc_q <= n_psq[63:0];
							anti_acc_q     <= n_anti[63:0];
							anti_sq_acc_q  <= n_asq[63:0];
							delta_acc_q    <= n_dlt[63:0];
							cnt_q          <= cnt_next;
							seen_q         <= seen_q | ovf_all;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_go) begin
					z_q    <= s_tdata;
					last_q <= s_tlast;
					ovf_q  <= 1'b0;
					leg_q  <= 1'b0;
				end
			end
			S_LOGX: begin
				if (!leg_q)
					t_q <= t_now;
				neg_q <= x_cur[36];
				rem_q <= rem_init;
			end
			// quotient estimate is exact or one short
			S_QMUL: quo_q <= prod[63:56];
			S_FIX: begin
				if (rfix >= DIV_D) begin
					rem_q <= rfix - DIV_D;
					quo_q <= quo_q + 8'd1;
				end else begin
					rem_q <= rfix;
				end
			end
			S_REDUCE: begin
				r_q      <= neg_q ? -32'(rmag) : 32'(rmag);
				k_q      <= neg_q ? -kq : kq;
				acc_q    <= exp_coef(EXP_POLY_DEGREE);
				horn_i_q <= HW'(EXP_POLY_DEGREE - 1);
			end
			S_H_TAKE: begin
				acc_q    <= exp_coef(int'(horn_i_q)) + $signed(prod[59:28]);
				horn_i_q <= horn_i_q - 1'b1;
			end
			S_RATIO: begin
				ratio_q <= sc.val;
				ovf_q   <= ovf_q | sc.ovf;
			end
			S_PRICE: begin
				ovf_q <= ovf_q | sc.ovf;
				if (leg_q) begin
					pay_m_q  <= (price > 64'(strike_q)) ? price - 64'(strike_q) : '0;
					dfac_m_q <= (price > 64'(strike_q)) ? ratio_q : '0;
				end else begin
					pay_p_q  <= (price > 64'(strike_q)) ? price - 64'(strike_q) : '0;
					dfac_p_q <= (price > 64'(strike_q)) ? ratio_q : '0;
				end
				leg_q <= 1'b1;
			end
			S_AVG: begin
				hs_pay_q <= half_sum(pay_p_q, pay_m_q);
				hs_d_q   <= half_sum(dfac_p_q, dfac_m_q);
				dsel_q   <= DS_PLAIN;
			end
			S_D_HI: dlo_q <= prod[63:31];
			S_D_SUM: begin
				ovf_q <= ovf_q | dovf;
				case (dsel_q)
					DS_PLAIN: begin
						plain_q <= dres;
						dsel_q  <= DS_ANTI;
					end
					DS_ANTI: begin
						anti_q <= dres;
						dsel_q <= DS_DELTA;
					end
					DS_DELTA: begin
						dlt_q   <= dres;
						sqsel_q <= 1'b0;
					end
					default: dsel_q <= DS_PLAIN;
				endcase
			end
			S_SQ_LH: sq_q <= 128'(prod[63:0]);
			S_SQ_HH: sq_q <= sq_q + (128'(prod[63:0]) << 33);
			S_SQ_END: begin
				ovf_q <= ovf_q | sq_ovf;
				if (sqsel_q)
					asq_q <= sq_res;
				else
					psq_q <= sq_res;
				sqsel_q <= 1'b1;
			end
			default: ;
		endcase
	end

	`MCPA_ASSERT_IMP(a_div_rem_bound, state_q == S_REDUCE, rem_q < DIV_D, "divider remainder out of range")
	`MCPA_ASSERT_IMP(a_horner_index, state_q == S_H_TAKE, int'(horn_i_q) < EXP_POLY_DEGREE, "horner index out of range")
	`MCPA_ASSERT_NXT(a_result_hold, state_q == S_ACC && last_q && m_tvalid && !m_tready, state_q == S_ACC, "pending result overwritten")
	`MCPA_ASSERT_IMP(a_count_limit, cnt_q[CW-1], cnt_q[CW-2:0] == '0, "path count past limit")

endmodule
